// ----- hdl/btc_pkg.sv -----
package btc_pkg;

  // width of the block_length register as seen on the register port
  localparam int BLEN_BITS = 5;

  typedef struct packed {
    logic [BLEN_BITS-1:0] block_length;
    logic                 decrypt_mode;
  } btc_cfg_t;

endpackage

// ----- hdl/btc_ram.sv -----
module btc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/btc_cfg.sv -----
module btc_cfg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output btc_pkg::btc_cfg_t       cfg
);

  localparam logic REG_BLOCK_LENGTH = 1'b0;
  localparam logic REG_DECRYPT_MODE = 1'b1;

  logic [btc_pkg::BLEN_BITS-1:0] blen_r;
  logic                          dec_r;
  logic                          reg_sel;
  logic                          wr_en;

  // byte address 4*i, so the register index is bit 2
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r <= btc_pkg::BLEN_BITS'(16);
      dec_r  <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BLOCK_LENGTH: blen_r <= pwdata[btc_pkg::BLEN_BITS-1:0];
        REG_DECRYPT_MODE: dec_r  <= pwdata[0];
        default:          blen_r <= blen_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BLOCK_LENGTH: prdata = 32'(blen_r);
      REG_DECRYPT_MODE: prdata = 32'(dec_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.block_length = blen_r;
  assign cfg.decrypt_mode = dec_r;

endmodule

// ----- hdl/btc_seq.sv -----
module btc_seq #(
  parameter int MAX_LEN     = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  btc_pkg::btc_cfg_t          cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [$clog2(MAX_LEN)-1:0] in_entry_index,
  input  logic [$clog2(MAX_LEN)-1:0] in_entry_value,
  input  logic [SYMBOL_BITS-1:0]     in_symbol,
  input  logic                       in_short_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [SYMBOL_BITS-1:0]     out_symbol,
  output logic                       out_block_end
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PCHK   = 3'd1;
  localparam logic [2:0] S_SWR    = 3'd2;
  localparam logic [2:0] S_OSTART = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [LW-1:0]      fill_r, fill_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      j_r, j_nxt;
  logic [LW-1:0]      i_r, i_nxt;
  logic [LW-1:0]      k_r, k_nxt;
  logic [AW-1:0]      dst_r, dst_nxt;
  logic [MAX_LEN-1:0] written_r, written_nxt;

  logic [LW-1:0]      plen;
  logic [LW-1:0]      pos;
  logic [LW-1:0]      pos_inc;
  logic [LW-1:0]      p_ext;
  logic [LW-1:0]      j_step;
  logic [LW-1:0]      i_step;
  logic               keep;
  logic               full_blk;
  logic               in_acc;
  logic               load_we;
  logic               data_we;

  logic               perm_re;
  logic [AW-1:0]      perm_raddr;
  logic [AW-1:0]      perm_rdata;
  logic               store_re;
  logic [AW-1:0]      store_raddr;
  logic [SYMBOL_BITS-1:0] store_rdata;
  logic               slot_re;
  logic [AW-1:0]      slot_raddr;
  logic [SYMBOL_BITS-1:0] slot_rdata;

  // effective permutation length: zero acts as one, clipped at MAX_LEN
  always_comb begin
    if (cfg.block_length == '0) begin
      plen = LW'(1);
    end else if (32'(cfg.block_length) > 32'(MAX_LEN)) begin
      plen = LW'(MAX_LEN);
    end else begin
      plen = LW'(cfg.block_length);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_we  = in_acc && (in_action == ACT_LOAD) &&
                    ({1'b0, in_entry_index} < (AW + 1)'(MAX_LEN));
  assign data_we  = in_acc && (in_action == ACT_DATA);

  // a held block as long as or longer than the current length is dropped
  assign pos      = (fill_r >= plen) ? '0 : fill_r;
  assign pos_inc  = pos + LW'(1);

  // shared compare step over the table
  assign p_ext    = LW'(perm_rdata);
  assign full_blk = (len_r == plen);
  assign keep     = (p_ext < len_r);
  assign j_step   = j_r + LW'(1);
  assign i_step   = (keep || full_blk) ? (i_r + LW'(1)) : i_r;

  btc_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_perm (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_entry_index),
    .wdata (in_entry_value),
    .re    (perm_re),
    .raddr (perm_raddr),
    .rdata (perm_rdata)
  );

  btc_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_store (
    .clk   (clk),
    .we    (data_we),
    .waddr (pos[AW-1:0]),
    .wdata (in_symbol),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  btc_ram #(.WIDTH(SYMBOL_BITS), .DEPTH(MAX_LEN)) u_slot (
    .clk   (clk),
    .we    (state_r == S_SWR),
    .waddr (dst_r),
    .wdata (store_rdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    len_nxt     = len_r;
    j_nxt       = j_r;
    i_nxt       = i_r;
    k_nxt       = k_r;
    dst_nxt     = dst_r;
    written_nxt = written_r;
    perm_re     = 1'b0;
    perm_raddr  = j_r[AW-1:0];
    store_re    = 1'b0;
    store_raddr = '0;
    slot_re     = 1'b0;
    slot_raddr  = k_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (data_we) begin
          if ((pos_inc < plen) && !in_short_end) begin
            fill_nxt = pos_inc;
          end else begin
            fill_nxt    = '0;
            len_nxt     = pos_inc;
            j_nxt       = '0;
            i_nxt       = '0;
            written_nxt = '0;
            perm_re     = 1'b1;
            perm_raddr  = '0;
            state_nxt   = S_PCHK;
          end
        end
      end
      S_PCHK: begin
        j_nxt = j_step;
        i_nxt = i_step;
        if (keep) begin
          store_re = 1'b1;
          if (cfg.decrypt_mode) begin
            store_raddr = perm_rdata;
            dst_nxt     = i_r[AW-1:0];
          end else begin
            store_raddr = i_r[AW-1:0];
            dst_nxt     = perm_rdata;
          end
          state_nxt = S_SWR;
        end else if ((j_step == plen) || (i_step == len_r)) begin
          state_nxt = S_OSTART;
        end else begin
          perm_re    = 1'b1;
          perm_raddr = j_step[AW-1:0];
        end
      end
      S_SWR: begin
        written_nxt[dst_r] = 1'b1;
        if ((j_r == plen) || (i_r == len_r)) begin
          state_nxt = S_OSTART;
        end else begin
          perm_re    = 1'b1;
          perm_raddr = j_r[AW-1:0];
          state_nxt  = S_PCHK;
        end
      end
      S_OSTART: begin
        k_nxt      = '0;
        slot_re    = 1'b1;
        slot_raddr = '0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (k_r == len_r - LW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt      = k_r + LW'(1);
            slot_re    = 1'b1;
            slot_raddr = k_nxt[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      written_r <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      written_r <= written_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    j_r   <= j_nxt;
    i_r   <= i_nxt;
    k_r   <= k_nxt;
    dst_r <= dst_nxt;
  end

  // slots never written read as zero
  assign out_valid     = (state_r == S_OUT);
  assign out_symbol    = written_r[k_r[AW-1:0]] ? slot_rdata : '0;
  assign out_block_end = (k_r == len_r - LW'(1));

  a_out_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> k_r < len_r)
    else $error("output index beyond block length");

  a_block_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    data_we && ((pos_inc == plen) || in_short_end) |=> state_r == S_PCHK)
    else $error("closing symbol did not start the table scan");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_block_end |=> state_r == S_IDLE)
    else $error("block end transaction did not release the input");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PCHK || state_r == S_SWR) |-> i_r <= j_r)
    else $error("position counter ran ahead of table index");

  a_fill_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> fill_r == '0)
    else $error("fill count not cleared while emitting");

endmodule

// ----- hdl/block_transposition_cipher.sv -----
// load items and data symbols that do not close a block do not stall the input
// a closing symbol starts a scan of the table: S_PCHK per entry, and S_SWR
//   after a used one (perm ram read, then store ram read and slot write)
// then setup in S_OSTART and output from S_OUT; input is stalled meanwhile
// synchronous active-low reset: block_length 16, encrypt mode, empty block;
//   the table and block store hold nothing defined until written
module block_transposition_cipher #(
  parameter int MAX_LEN     = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [$clog2(MAX_LEN)-1:0] in_entry_index,
  input  logic [$clog2(MAX_LEN)-1:0] in_entry_value,
  input  logic [SYMBOL_BITS-1:0]     in_symbol,
  input  logic                       in_short_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [SYMBOL_BITS-1:0]     out_symbol,
  output logic                       out_block_end
);

  btc_pkg::btc_cfg_t cfg;

  btc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  btc_seq #(.MAX_LEN(MAX_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_entry_index (in_entry_index),
    .in_entry_value (in_entry_value),
    .in_symbol      (in_symbol),
    .in_short_end   (in_short_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .out_block_end  (out_block_end)
  );

endmodule

// ----- sim/btc_tb_pkg.sv -----
package btc_tb_pkg;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DATA = 1'b1
  } btc_action_e;

  typedef enum int {
    REG_BLOCK_LENGTH = 0,
    REG_DECRYPT_MODE = 1
  } btc_reg_e;

  // byte spacing of the registers on the config port
  localparam int REG_STRIDE = 4;

endpackage

// ----- sim/block_transposition_cipher_checker.sv -----
module block_transposition_cipher_checker #(
  parameter int MAX_LEN     = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_action,
  input  logic [$clog2(MAX_LEN)-1:0] in_entry_index,
  input  logic [$clog2(MAX_LEN)-1:0] in_entry_value,
  input  logic [SYMBOL_BITS-1:0]     in_symbol,
  input  logic                       in_short_end,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [SYMBOL_BITS-1:0]     out_symbol,
  input  logic                       out_block_end,
  output int                         fail_count,
  output int                         pending,
  output int                         checked
);
  import btc_pkg::*;
  import btc_tb_pkg::*;

  localparam int IDX_BITS = $clog2(MAX_LEN);

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym;
    logic                   last;
  } cipher_result_t;

  cipher_result_t         expected_symbols[$];
  logic [IDX_BITS-1:0]    perm_mem [MAX_LEN];
  logic [SYMBOL_BITS-1:0] held_sym [MAX_LEN];
  int                     held_count;
  btc_cfg_t               cfg_shadow;

  function automatic int active_len();
    if (cfg_shadow.block_length == 0) return 1;
    if (cfg_shadow.block_length > MAX_LEN) return MAX_LEN;
    return int'(cfg_shadow.block_length);
  endfunction

  task automatic permute_transaction(input logic act, input logic [IDX_BITS-1:0] idx,
                                     input logic [IDX_BITS-1:0] val,
                                     input logic [SYMBOL_BITS-1:0] sym,
                                     input logic short_end);
    int plen;
    int len;
    int j;
    logic [SYMBOL_BITS-1:0] slots [MAX_LEN];
    cipher_result_t r;
    plen = active_len();
    if (act == ACT_LOAD) begin
      if (idx < MAX_LEN) perm_mem[idx] = val;
      return;
    end
    // block length shrunk to or below the held count: start over
    if (held_count >= plen) held_count = 0;
    held_sym[held_count] = sym;
    held_count++;
    if (held_count < plen && !short_end) return;

    len = held_count;
    held_count = 0;
    for (int i = 0; i < MAX_LEN; i++) slots[i] = '0;

    if (len == plen) begin
      for (int i = 0; i < plen; i++) begin
        if (perm_mem[i] >= plen) continue;
        if (cfg_shadow.decrypt_mode) slots[i] = held_sym[perm_mem[i]];
        else slots[perm_mem[i]] = held_sym[i];
      end
    end else begin
      // short block walks the table, skipping entries that point past its end
      j = 0;
      for (int i = 0; i < len; i++) begin
        while (j < plen && perm_mem[j] >= len) j++;
        if (j >= plen) break;
        if (cfg_shadow.decrypt_mode) slots[i] = held_sym[perm_mem[j]];
        else slots[perm_mem[j]] = held_sym[i];
        j++;
      end
    end

    for (int i = 0; i < len; i++) begin
      r.sym  = slots[i];
      r.last = (i + 1 == len);
      expected_symbols.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    cipher_result_t exp_r;
    if (!rst_n) begin
      held_count = 0;
      cfg_shadow.block_length = 16;
      cfg_shadow.decrypt_mode = 1'b0;
      expected_symbols.delete();
      for (int i = 0; i < MAX_LEN; i++) perm_mem[i] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'(REG_STRIDE * REG_BLOCK_LENGTH))
          cfg_shadow.block_length = pwdata[BLEN_BITS-1:0];
        else if (paddr == 3'(REG_STRIDE * REG_DECRYPT_MODE))
          cfg_shadow.decrypt_mode = pwdata[0];
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_symbols.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transaction, out_symbol %02h out_block_end %0b",
                   $time, out_symbol, out_block_end);
        end else begin
          exp_r = expected_symbols.pop_front();
          if (out_symbol !== exp_r.sym || out_block_end !== exp_r.last) begin
            fail_count++;
            if (out_symbol !== exp_r.sym)
              $display("%0t: out_symbol mismatch, expected %02h, actual %02h",
                       $time, exp_r.sym, out_symbol);
            if (out_block_end !== exp_r.last)
              $display("%0t: out_block_end mismatch, expected %0b, actual %0b",
                       $time, exp_r.last, out_block_end);
          end
        end
      end
      if (in_valid && !in_stall)
        permute_transaction(in_action, in_entry_index, in_entry_value, in_symbol,
                            in_short_end);
    end
    pending = expected_symbols.size();
  end

endmodule

// ----- sim/block_transposition_cipher_tb.sv -----
module block_transposition_cipher_tb;
  import btc_pkg::*;
  import btc_tb_pkg::*;

  localparam int MAX_LEN       = 16;
  localparam int SYMBOL_BITS   = 8;
  localparam int IDX_BITS      = $clog2(MAX_LEN);
  localparam int CYCLE_LIMIT   = 100000;
  localparam int HOLD_CYCLES   = 150;
  localparam int SEGMENT_ITEMS = 8;
  localparam int DRAIN_GAP     = 20;
  localparam int END_GAP       = 60;
  localparam int NUM_SEGMENTS  = 8;
  localparam int MAX_LEFTOVER  = 4;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   in_action = 1'b0;
  logic [IDX_BITS-1:0]    in_entry_index = '0;
  logic [IDX_BITS-1:0]    in_entry_value = '0;
  logic [SYMBOL_BITS-1:0] in_symbol = '0;
  logic                   in_short_end = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SYMBOL_BITS-1:0] out_symbol;
  logic                   out_block_end;

  int fail_count;
  int pending;
  int checked;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_asks;
  int hold_seen;
  int hold_left;
  int cycles;
  int items_sent;
  int loads_sent;
  int seg_items;
  int settings_used;
  int cur_plen;
  logic [IDX_BITS-1:0] key_perm [MAX_LEN];

  block_transposition_cipher #(
    .MAX_LEN(MAX_LEN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) dut (.*);

  block_transposition_cipher_checker #(
    .MAX_LEN(MAX_LEN),
    .SYMBOL_BITS(SYMBOL_BITS)
  ) chk (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycles, pending);
      $display("block_transposition_cipher_tb: FAIL");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic write_reg(input btc_reg_e reg_id, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(REG_STRIDE * reg_id);
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send(input btc_action_e act, input logic [IDX_BITS-1:0] idx,
                      input logic [IDX_BITS-1:0] val, input logic [SYMBOL_BITS-1:0] sym,
                      input logic short_end);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_action      <= act;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_symbol      <= sym;
    in_short_end   <= short_end;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    seg_items++;
    if (act == ACT_LOAD) loads_sent++;
  endtask

  task automatic load_entry(input int idx, input int val);
    key_perm[idx] = IDX_BITS'(val);
    send(ACT_LOAD, IDX_BITS'(idx), IDX_BITS'(val), SYMBOL_BITS'($urandom),
         1'($urandom_range(1)));
  endtask

  task automatic push_symbol(input int sym, input logic short_end);
    send(ACT_DATA, IDX_BITS'($urandom), IDX_BITS'($urandom), SYMBOL_BITS'(sym), short_end);
  endtask

  task automatic drain();
    // stop offering the last transaction before waiting
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic configure(input int blen, input int dmode);
    drain();
    write_reg(REG_BLOCK_LENGTH, blen);
    write_reg(REG_DECRYPT_MODE, dmode);
    settings_used++;
    cur_plen = (blen == 0) ? 1 : (blen > MAX_LEN) ? MAX_LEN : blen;
  endtask

  // fresh random permutation of 0..n-1 into the first n entries
  task automatic load_perm(input int n);
    int order [MAX_LEN];
    int k;
    int t;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(i);
      t = order[i];
      order[i] = order[k];
      order[k] = t;
    end
    for (int i = 0; i < n; i++) load_entry(i, order[i]);
  endtask

  task automatic swap_entries();
    int a;
    int b;
    int va;
    int vb;
    a = $urandom_range(cur_plen - 1);
    b = $urandom_range(cur_plen - 1);
    va = key_perm[a];
    vb = key_perm[b];
    load_entry(a, vb);
    load_entry(b, va);
  endtask

  task automatic noise_load();
    load_entry($urandom_range(MAX_LEN - 1), $urandom_range(MAX_LEN - 1));
  endtask

  task automatic send_block(input int len, input logic is_short);
    logic se;
    for (int i = 0; i < len; i++) begin
      // table loads may land in the middle of a block
      if ($urandom_range(99) < 5) noise_load();
      se = (is_short && i == len - 1) || ($urandom_range(99) < 4);
      push_symbol($urandom_range(255), se);
    end
  endtask

  initial begin
    int seg_len [NUM_SEGMENTS];
    int seg_mode [NUM_SEGMENTS];
    int r;
    seg_len  = '{16, 3, 1, 16, 31, 0, 7, 0};
    seg_mode = '{0, 1, 0, 1, 0, 1, 1, 0};
    seg_len[7]  = $urandom_range(31);
    seg_mode[7] = $urandom_range(1);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: table of four plus identity, full and short blocks both ways
    configure(4, 0);
    for (int i = 0; i < MAX_LEN; i++)
      load_entry(i, (i == 0) ? 2 : (i == 1) ? 0 : (i == 2) ? 3 : (i == 3) ? 1 : i);
    push_symbol(8'h00, 1'b0);
    push_symbol(8'hff, 1'b0);
    push_symbol(8'h5a, 1'b0);
    push_symbol(8'ha5, 1'b0);
    push_symbol(8'h3c, 1'b0);
    push_symbol(8'hc3, 1'b1);
    configure(4, 1);
    push_symbol(8'h01, 1'b0);
    push_symbol(8'h80, 1'b0);
    push_symbol(8'h7f, 1'b0);
    push_symbol(8'hfe, 1'b0);
    push_symbol(8'h96, 1'b1);

    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      if (s < 3) begin
        tx_idle_pct = 7;
        rx_idle_pct = 82;
      end else if (s < 6) begin
        tx_idle_pct = 82;
        rx_idle_pct = 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      configure(seg_len[s], seg_mode[s]);
      seg_items = 0;
      if (cur_plen <= 8 || $urandom_range(1)) load_perm(cur_plen);
      else repeat (3) swap_entries();
      if (s == 6) begin
        // two blocks under a long hold-off: the second one runs into a full block
        hold_asks++;
        send_block(cur_plen, 1'b0);
        send_block(cur_plen, 1'b0);
      end
      while (seg_items < SEGMENT_ITEMS) begin
        r = $urandom_range(99);
        if (r < 8) load_perm(cur_plen);
        else if (r < 20) swap_entries();
        else if (r < 25) noise_load();
        else if (r < 70) send_block(cur_plen, 1'b0);
        else send_block($urandom_range(1, cur_plen), 1'b1);
      end
      // leave a partial block behind for the next setting to pick up or drop
      repeat ($urandom_range((cur_plen > MAX_LEFTOVER) ? MAX_LEFTOVER : cur_plen - 1))
        push_symbol($urandom_range(255), 1'b0);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (END_GAP) @(negedge clk);

    $display("covered %0d input transactions (%0d table loads) over %0d register settings",
             items_sent, loads_sent, settings_used);
    $display("%0d result transactions checked, %0d failures", checked, fail_count);
    if (fail_count == 0) begin
      $display("block_transposition_cipher_tb: PASS");
    end else begin
      $display("block_transposition_cipher_tb: FAIL");
    end
    $finish;
  end

endmodule
